// ===== hw/rtl/bcrush_pkg.sv =====
// Shared types and constants for the bit crusher effect.
package bcrush_pkg;

    // Sample format: signed Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS = 24;

    // Mix control scaled by 2^MIX_SHIFT
    localparam int MIX_SHIFT = 16;
    localparam int MIX_W     = MIX_SHIFT + 1;
    localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(1) << MIX_SHIFT;

    // Bit depth control
    localparam int DEPTH_W = 5;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(16);

    // Quantizer shift amount, wide enough to hold SAMPLE_BITS itself
    localparam int SHIFT_W = $clog2(SAMPLE_BITS + 1);

    // Hold rate step
    localparam int RATE_W = 17;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

    // Configuration port
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BIT_DEPTH = 2'd0,
        REG_RATE_STEP = 2'd1,
        REG_MIX       = 2'd2,
        REG_STEREO    = 2'd3
    } cfg_reg_t;

    // Current settings, already clamped to their legal ranges
    typedef struct packed {
        logic [DEPTH_W-1:0] bit_depth;
        logic [RATE_W-1:0]  rate_step;
        logic [MIX_W-1:0]   mix;
        logic               stereo_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } sample_frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } result_frame_t;

endpackage

// ===== hw/rtl/bcrush_cfg.sv =====
// Configuration registers with range clamping on write.
module bcrush_cfg
    import bcrush_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic [DEPTH_W-1:0]  depth_in;
    logic [MIX_W-1:0]    mix_in;

    assign depth_in = cfg_data[DEPTH_W-1:0];
    assign mix_in   = cfg_data[MIX_W-1:0];

    // Decode the write and clamp depth and mix into range
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BIT_DEPTH:
                begin
                    if (depth_in < DEPTH_MIN)
                        cfg_next.bit_depth = DEPTH_MIN;
                    else if (depth_in > DEPTH_MAX)
                        cfg_next.bit_depth = DEPTH_MAX;
                    else
                        cfg_next.bit_depth = depth_in;
                end
                REG_RATE_STEP: cfg_next.rate_step = cfg_data[RATE_W-1:0];
                REG_MIX:
                begin
                    if (mix_in > MIX_ONE)
                        cfg_next.mix = MIX_ONE;
                    else
                        cfg_next.mix = mix_in;
                end
                REG_STEREO:    cfg_next.stereo_enable = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_depth     <= DEPTH_MAX;
            cfg_reg.rate_step     <= RATE_RESET;
            cfg_reg.mix           <= MIX_ONE;
            cfg_reg.stereo_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bcrush_quant.sv =====
// Requantizer: round half away from zero to bit_depth-1 fraction bits, saturate high.
module bcrush_quant
    import bcrush_pkg::*;
(
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [DEPTH_W-1:0]            bit_depth,
    output logic signed [SAMPLE_BITS-1:0] quant
);

    localparam int MW = SAMPLE_BITS + 1;
    localparam logic [MW-1:0] POS_MAX = {2'b00, {(SAMPLE_BITS-1){1'b1}}};

    logic              neg;
    logic [MW-1:0]     ext;
    logic [MW-1:0]     mag;
    logic [SHIFT_W-1:0] shift;
    logic [MW-1:0]     half;
    logic [MW-1:0]     keep;
    logic [MW-1:0]     rnd;
    logic [MW-1:0]     rnd_neg;

    // Take the magnitude one bit wider so the most negative value fits
    assign neg  = sample[SAMPLE_BITS-1];
    assign ext  = {sample[SAMPLE_BITS-1], sample};
    assign mag  = neg ? (~ext + MW'(1)) : ext;

    // Drop the low bits below the kept resolution, rounding by half a step
    assign shift = SHIFT_W'(SAMPLE_BITS) - SHIFT_W'(bit_depth);
    assign half  = (shift == '0) ? '0 : (MW'(1) << (shift - SHIFT_W'(1)));
    assign keep  = ~((MW'(1) << shift) - MW'(1));
    assign rnd   = (mag + half) & keep;
    assign rnd_neg = ~rnd + MW'(1);

    // Restore the sign; only a positive result can overflow
    always_comb
    begin
        if (neg)
            quant = rnd_neg[SAMPLE_BITS-1:0];
        else if (rnd > POS_MAX)
            quant = POS_MAX[SAMPLE_BITS-1:0];
        else
            quant = rnd[SAMPLE_BITS-1:0];
    end

endmodule

// ===== hw/rtl/bcrush_mix.sv =====
// Dry/held crossfade: dry + round((held - dry) * mix / 2^16), half up.
module bcrush_mix
    import bcrush_pkg::*;
(
    input  logic signed [SAMPLE_BITS-1:0] dry,
    input  logic signed [SAMPLE_BITS-1:0] held,
    input  logic [MIX_W-1:0]              mix,
    output logic signed [SAMPLE_BITS-1:0] mixed
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + MIX_W + 1;
    localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (MIX_SHIFT - 1);

    logic signed [DW-1:0]        diff;
    logic signed [MIX_W:0]       mix_s;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        scaled;
    logic signed [SAMPLE_BITS-1:0] delta;

    // Form the wet-minus-dry difference and weight it
    assign diff   = {held[SAMPLE_BITS-1], held} - {dry[SAMPLE_BITS-1], dry};
    assign mix_s  = {1'b0, mix};
    assign prod   = PW'(diff) * PW'(mix_s);

    // Round half up and scale back; the sum always lands in sample range
    assign scaled = (prod + ROUND) >>> MIX_SHIFT;
    assign delta  = scaled[SAMPLE_BITS-1:0];
    assign mixed  = dry + delta;

endmodule

// ===== hw/rtl/bit_crusher_effect.sv =====
// Top level of the sample-and-hold bit crusher effect.
//
//  Channel   Direction  Handshake                      Payload
//  sample    in         sample_valid / sample_ready    sample_frame_t (left, right)
//  result    out        result_valid / result_ready    result_frame_t (left, right)
//  cfg       in         cfg_write (no wait)            cfg_index, cfg_data
//
//  One frame per cycle sustained while result_ready stays high; two register stages, so a
//  result reaches the result register after its request is accepted into stage one.
//  Stage one holds the accepted frame; quantize and crossfade run between it and
//  the result register, and the phase and held samples update as a frame moves on.
//  A stalled result holds both stages; sample_ready drops only when both are full.
//  Reset clears phase and held samples and loads bit_depth 16, rate_step 65536,
//  mix 65536 and stereo on.
module bit_crusher_effect
    import bcrush_pkg::*;
#(
    parameter int PHASE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_frame_t          sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_frame_t          result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = ((PHASE_BITS > RATE_W) ? PHASE_BITS : RATE_W) + 1;

    cfg_t                          cfg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    sample_frame_t                 s1_frame_reg;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    result_frame_t                 res_frame_reg;
    logic [PHASE_BITS-1:0]         phase_reg;
    logic signed [SAMPLE_BITS-1:0] held_left_reg;
    logic signed [SAMPLE_BITS-1:0] held_right_reg;
    logic                          s1_go;
    logic                          advance;
    logic [SUM_W-1:0]              phase_sum;
    logic                          wrap;
    logic signed [SAMPLE_BITS-1:0] quant_left;
    logic signed [SAMPLE_BITS-1:0] quant_right;
    logic signed [SAMPLE_BITS-1:0] held_left_next;
    logic signed [SAMPLE_BITS-1:0] held_right_next;
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    result_frame_t                 res_frame_next;

    bcrush_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: stage one moves on whenever the result register is free or drains
    assign s1_go        = !res_valid_reg || result_ready;
    assign advance      = s1_valid_reg && s1_go;
    assign sample_ready = !s1_valid_reg || s1_go;

    assign s1_valid_next  = (sample_valid && sample_ready) || (s1_valid_reg && !s1_go);
    assign res_valid_next = advance || (res_valid_reg && !result_ready);

    // Phase accumulator: a carry past 2^PHASE_BITS triggers a new hold
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(cfg.rate_step);
    assign wrap      = |phase_sum[SUM_W-1:PHASE_BITS];

    bcrush_quant u_quant_left (
        .sample    (s1_frame_reg.left_sample),
        .bit_depth (cfg.bit_depth),
        .quant     (quant_left)
    );

    bcrush_quant u_quant_right (
        .sample    (s1_frame_reg.right_sample),
        .bit_depth (cfg.bit_depth),
        .quant     (quant_right)
    );

    // Update held samples before they feed this frame's crossfade
    assign held_left_next  = wrap ? quant_left : held_left_reg;
    assign held_right_next = (wrap && cfg.stereo_enable) ? quant_right : held_right_reg;

    bcrush_mix u_mix_left (
        .dry   (s1_frame_reg.left_sample),
        .held  (held_left_next),
        .mix   (cfg.mix),
        .mixed (mix_left)
    );

    bcrush_mix u_mix_right (
        .dry   (s1_frame_reg.right_sample),
        .held  (held_right_next),
        .mix   (cfg.mix),
        .mixed (mix_right)
    );

    // Pass the right channel through when stereo is off
    always_comb
    begin
        res_frame_next.left_out  = mix_left;
        res_frame_next.right_out = cfg.stereo_enable ? mix_right
                                                     : s1_frame_reg.right_sample;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg      <= phase_sum[PHASE_BITS-1:0];
                held_left_reg  <= held_left_next;
                held_right_reg <= held_right_next;
            end
        end
    end

    // Payload registers: load the input stage and the result stage
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            s1_frame_reg <= sample;
        if (advance)
            res_frame_reg <= res_frame_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_frame_reg;

endmodule

// ===== hw/rtl/bcrush_checker.sv =====
// Port-level checks for the bit crusher effect, bound to its top level.
module bcrush_checker
    import bcrush_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_ready,
    input sample_frame_t          sample,
    input logic                   result_valid,
    input logic                   result_ready,
    input result_frame_t          result,
    input logic                   cfg_write,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // Hold a stalled result request steady
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A rising result_valid traces back to an accepted request that passed through stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
        else $error("result without a matching request");

    // Backpressure reaches the input only when a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("sample_ready low with no stalled result");

    // Hold a waiting input request steady
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("sample request changed before acceptance");

    // Write settings only with no result pending and a known register and value
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> !result_valid && !$isunknown({cfg_index, cfg_data}))
        else $error("configuration write while busy or unknown");

endmodule

bind bit_crusher_effect bcrush_checker u_bcrush_checker (.*);
